// File: rtl/core/tun_pkg.sv
// shared widths and types for the triangle unit normal pipeline
package tun_pkg;

    localparam int COORD_W = 24;
    localparam int NORM_W  = 16;

    // edge, product, cross and magnitude widths
    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int HALF_W  = MAG_W / 2;
    localparam int RAD_W   = 2 * MAG_W;
    localparam int ROOT_W  = MAG_W;

    // long division: quotient bits and remainder width
    localparam int QUO_W   = NORM_W + 1;
    localparam int DIV_W   = MAG_W + QUO_W;

    // saturation limit of a normal component
    localparam logic [QUO_W-1:0] NORM_LIM = QUO_W'((1 << (NORM_W - 1)) - 1);

    // register stages ahead of the output register
    localparam int FRONT_STAGES = 6;
    localparam int STAGES       = FRONT_STAGES + ROOT_W + 1 + QUO_W;

    // per-item data carried alongside the square root
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } side_t;

endpackage

// File: rtl/core/triangle_unit_normal_top.sv
// triangle unit normal: fully pipelined cross product, isqrt and divide
//
// Input channel in_valid/in_ready carries one triangle (a_*, b_*, c_*), signed
// fixed point with 8 fraction bits. Output channel out_valid/out_ready carries
// normal_x/y/z in Q1.15, saturated to +/-32767, and the degenerate flag, which
// is set with all components zero when the cross product is the zero vector.
// From input accept to out_valid an item passes the edge, cross product and
// sum of squares stages, the one-bit-per-stage square root, the
// one-bit-per-stage divide and the output register. Throughput is one item per
// cycle unless the receiver stalls; the root and divide stages set the depth.
// Items leave in the order they enter, one result per item.
// Reset clears all valid bits and the output buffer; in_ready is high right
// after reset. When the receiver stalls, the pipeline keeps moving until a
// second finished item sits in the skid register behind the output register;
// then in_ready drops and the whole pipeline holds until out_ready returns.
module triangle_unit_normal_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tun_pkg::COORD_W-1:0]   a_x,
    input  logic signed [tun_pkg::COORD_W-1:0]   a_y,
    input  logic signed [tun_pkg::COORD_W-1:0]   a_z,
    input  logic signed [tun_pkg::COORD_W-1:0]   b_x,
    input  logic signed [tun_pkg::COORD_W-1:0]   b_y,
    input  logic signed [tun_pkg::COORD_W-1:0]   b_z,
    input  logic signed [tun_pkg::COORD_W-1:0]   c_x,
    input  logic signed [tun_pkg::COORD_W-1:0]   c_y,
    input  logic signed [tun_pkg::COORD_W-1:0]   c_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tun_pkg::NORM_W-1:0]    normal_x,
    output logic signed [tun_pkg::NORM_W-1:0]    normal_y,
    output logic signed [tun_pkg::NORM_W-1:0]    normal_z,
    output logic                                 degenerate
);
    import tun_pkg::*;

    // pipeline control
    logic               en;
    logic [STAGES-1:0]  vld_reg;
    logic [STAGES-1:0]  vld_next;
    logic               out_valid_reg;
    logic               skid_valid_reg;

    // front stages
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [EDGE_W-1:0]  e1_next [3];
    logic signed [EDGE_W-1:0]  e2_next [3];
    logic signed [PROD_W-1:0]  pa_reg [3];
    logic signed [PROD_W-1:0]  pb_reg [3];
    logic signed [CROSS_W-1:0] cross_reg [3];
    side_t                     s4_side_reg;
    side_t                     s4_side_next;
    logic [2*HALF_W-1:0]       hh_reg [3];
    logic [2*HALF_W-1:0]       hl_reg [3];
    logic [2*HALF_W-1:0]       ll_reg [3];
    side_t                     s5_side_reg;
    logic [RAD_W-1:0]          sqr_reg [3];
    side_t                     s6_side_reg;

    // square root stages, index 0 holds the radicand
    logic [RAD_W-1:0]  sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [0:ROOT_W];
    side_t             sq_side_reg [0:ROOT_W];

    // divide stages
    logic [DIV_W-1:0]  dv_rem_reg  [1:QUO_W][3];
    logic [QUO_W-1:0]  dv_quo_reg  [1:QUO_W][3];
    logic [MAG_W-1:0]  dv_div_reg  [1:QUO_W];
    logic [2:0]        dv_neg_reg  [1:QUO_W];
    logic              dv_zero_reg [1:QUO_W];

    // final result and output buffer
    logic signed [NORM_W-1:0] res_next [3];
    logic signed [NORM_W-1:0] out_n_reg [3];
    logic signed [NORM_W-1:0] skid_n_reg [3];
    logic                     out_deg_reg;
    logic                     skid_deg_reg;
    logic                     load_out;
    logic                     push;
    logic                     pop;

    // the pipeline moves whenever the skid register is free
    assign en       = !skid_valid_reg;
    assign in_ready = en;
    assign vld_next = {vld_reg[STAGES-2:0], in_valid};

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: edges
    always_comb
    begin
        e1_next[0] = EDGE_W'(b_x) - EDGE_W'(a_x);
        e1_next[1] = EDGE_W'(b_y) - EDGE_W'(a_y);
        e1_next[2] = EDGE_W'(b_z) - EDGE_W'(a_z);
        e2_next[0] = EDGE_W'(c_x) - EDGE_W'(a_x);
        e2_next[1] = EDGE_W'(c_y) - EDGE_W'(a_y);
        e2_next[2] = EDGE_W'(c_z) - EDGE_W'(a_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
        end
    end

    // stages 2 and 3: cross product terms, then their difference
    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg[i]    <= e1_reg[J] * e2_reg[K];
                pb_reg[i]    <= e1_reg[K] * e2_reg[J];
                cross_reg[i] <= CROSS_W'(pa_reg[i]) - CROSS_W'(pb_reg[i]);
            end
        end
    end

    // stage 4: sign and magnitude
    always_comb
    begin
        s4_side_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            s4_side_next.neg[i] = cross_reg[i][CROSS_W-1];
            s4_side_next.mag[i] = cross_reg[i][CROSS_W-1] ? MAG_W'(-cross_reg[i])
                                                          : MAG_W'(cross_reg[i]);
        end
        s4_side_next.zero = (cross_reg[0] == '0) && (cross_reg[1] == '0)
                         && (cross_reg[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s4_side_next;
        end
    end

    // stages 5 and 6: squares from half-width partial products
    for (genvar i = 0; i < 3; i++)
    begin : g_square
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hh_reg[i]  <= s4_side_reg.mag[i][MAG_W-1:HALF_W]
                            * s4_side_reg.mag[i][MAG_W-1:HALF_W];
                hl_reg[i]  <= s4_side_reg.mag[i][MAG_W-1:HALF_W]
                            * s4_side_reg.mag[i][HALF_W-1:0];
                ll_reg[i]  <= s4_side_reg.mag[i][HALF_W-1:0]
                            * s4_side_reg.mag[i][HALF_W-1:0];
                sqr_reg[i] <= (RAD_W'(hh_reg[i]) << (2 * HALF_W))
                            + (RAD_W'(hl_reg[i]) << (HALF_W + 1))
                            + RAD_W'(ll_reg[i]);
            end
        end
    end

    // stage 7: sum of squares is the radicand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg    <= s4_side_reg;
            s6_side_reg    <= s5_side_reg;
            sq_rem_reg[0]  <= sqr_reg[0] + sqr_reg[1] + sqr_reg[2];
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= s6_side_reg;
        end
    end

    // square root, one root bit per stage from the top
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [RAD_W-1:0] trial;
        logic             fits;

        assign trial = (RAD_W'(sq_root_reg[k]) << (B + 1)) | (RAD_W'(1) << (2 * B));
        assign fits  = sq_rem_reg[k] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[k+1]  <= fits ? sq_rem_reg[k] - trial : sq_rem_reg[k];
                sq_root_reg[k+1] <= fits ? sq_root_reg[k] | (ROOT_W'(1) << B)
                                         : sq_root_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // divide |n| * 2^(NORM_W-1) by the root, one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int B = QUO_W - 1 - k;
        logic [MAG_W-1:0] div_cur;
        logic [2:0]       neg_cur;
        logic             zero_cur;
        logic [DIV_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign div_cur  = sq_root_reg[ROOT_W];
            assign neg_cur  = sq_side_reg[ROOT_W].neg;
            assign zero_cur = sq_side_reg[ROOT_W].zero;
        end
        else
        begin : g_next
            assign div_cur  = dv_div_reg[k];
            assign neg_cur  = dv_neg_reg[k];
            assign zero_cur = dv_zero_reg[k];
        end

        assign trial = DIV_W'(div_cur) << B;

        for (genvar c = 0; c < 3; c++)
        begin : g_comp
            logic [DIV_W-1:0] rem_cur;
            logic [QUO_W-1:0] quo_cur;
            logic             fits;

            if (k == 0)
            begin : g_first
                assign rem_cur = DIV_W'(sq_side_reg[ROOT_W].mag[c]) << (NORM_W - 1);
                assign quo_cur = '0;
            end
            else
            begin : g_next
                assign rem_cur = dv_rem_reg[k][c];
                assign quo_cur = dv_quo_reg[k][c];
            end

            assign fits = rem_cur >= trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[k+1][c] <= fits ? rem_cur - trial : rem_cur;
                    dv_quo_reg[k+1][c] <= fits ? quo_cur | (QUO_W'(1) << B) : quo_cur;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_div_reg[k+1]  <= div_cur;
                dv_neg_reg[k+1]  <= neg_cur;
                dv_zero_reg[k+1] <= zero_cur;
            end
        end
    end

    // saturate, apply sign, zero out a degenerate triangle
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [QUO_W-1:0] sat;
            sat = (dv_quo_reg[QUO_W][c] > NORM_LIM) ? NORM_LIM : dv_quo_reg[QUO_W][c];
            if (dv_zero_reg[QUO_W])
            begin
                res_next[c] = '0;
            end
            else if (dv_neg_reg[QUO_W][c])
            begin
                res_next[c] = -NORM_W'(sat);
            end
            else
            begin
                res_next[c] = NORM_W'(sat);
            end
        end
    end

    // output register with a skid register behind it
    assign push     = en && vld_reg[STAGES-1];
    assign pop      = out_valid_reg && out_ready;
    assign load_out = !out_valid_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_n_reg   <= skid_valid_reg ? skid_n_reg : res_next;
            out_deg_reg <= skid_valid_reg ? skid_deg_reg : dv_zero_reg[QUO_W];
        end
        if (push && (skid_valid_reg || !load_out))
        begin
            skid_n_reg   <= res_next;
            skid_deg_reg <= dv_zero_reg[QUO_W];
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = out_n_reg[0];
    assign normal_y   = out_n_reg[1];
    assign normal_z   = out_n_reg[2];
    assign degenerate = out_deg_reg;

endmodule

// File: rtl/core/tun_checker.sv
// port-level checks for the triangle unit normal block, bound to the top level
module tun_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [tun_pkg::NORM_W-1:0]   normal_x,
    input logic signed [tun_pkg::NORM_W-1:0]   normal_y,
    input logic signed [tun_pkg::NORM_W-1:0]   normal_z,
    input logic                                degenerate
);
    import tun_pkg::*;

    localparam logic signed [NORM_W-1:0] MOST_NEG = {1'b1, {(NORM_W-1){1'b0}}};

    // a degenerate item carries zero components
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate item with nonzero normal");

    // saturation never yields the most negative code
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x != MOST_NEG && normal_y != MOST_NEG && normal_z != MOST_NEG)
        else $error("normal component outside saturation range");

    // input backpressure only follows an output stall
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("in_ready low without a stalled output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
        && $stable(normal_z) && $stable(degenerate))
        else $error("stalled output item changed");

endmodule

bind triangle_unit_normal_top tun_checker u_tun_checker (.*);

// File: test/tb.sv
// testbench for the triangle unit normal pipeline: random and directed triangles
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tun_pkg::*;

    localparam int N_RANDOM   = 1625;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 100;
    localparam longint LIMIT  = 400000;

    typedef struct {
        logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } triangle_t;

    typedef struct {
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic                     degen;
    } normal_t;

    // expected unit normals, oldest first
    class normal_scoreboard;
        normal_t pending[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        // scale one cross component by 2^15 / magnitude, saturate, apply sign
        static function logic signed [NORM_W-1:0] scale(longint comp, logic [127:0] root);
            logic [127:0] num;
            logic [127:0] quo;
            logic [NORM_W-1:0] v;
            num = (comp < 0) ? 128'(-comp) : 128'(comp);
            quo = (num << (NORM_W - 1)) / root;
            if (quo > 128'((1 << (NORM_W - 1)) - 1))
                quo = 128'((1 << (NORM_W - 1)) - 1);
            v = quo[NORM_W-1:0];
            return (comp < 0) ? -v : v;
        endfunction

        static function normal_t face_normal(triangle_t t);
            longint e1x, e1y, e1z, e2x, e2y, e2z, crx, cry, crz;
            logic [127:0] sum, root, probe;
            normal_t r;
            e1x = longint'(t.bx) - longint'(t.ax);
            e1y = longint'(t.by) - longint'(t.ay);
            e1z = longint'(t.bz) - longint'(t.az);
            e2x = longint'(t.cx) - longint'(t.ax);
            e2y = longint'(t.cy) - longint'(t.ay);
            e2z = longint'(t.cz) - longint'(t.az);
            crx = e1y * e2z - e1z * e2y;
            cry = e1z * e2x - e1x * e2z;
            crz = e1x * e2y - e1y * e2x;
            sum = 128'(crx < 0 ? -crx : crx) * 128'(crx < 0 ? -crx : crx)
                + 128'(cry < 0 ? -cry : cry) * 128'(cry < 0 ? -cry : cry)
                + 128'(crz < 0 ? -crz : crz) * 128'(crz < 0 ? -crz : crz);
            if (sum == 0)
            begin
                r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1'b1;
                return r;
            end
            // floor square root, one bit at a time
            root = 0;
            for (int b = 63; b >= 0; b--)
            begin
                probe = root | (128'(1) << b);
                if (probe * probe <= sum)
                    root = probe;
            end
            r.nx = scale(crx, root);
            r.ny = scale(cry, root);
            r.nz = scale(crz, root);
            r.degen = 1'b0;
            return r;
        endfunction

        function void note_triangle(triangle_t t);
            pending.push_back(face_normal(t));
        endfunction

        function void check_normal(normal_t act);
            normal_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d degenerate=%0b",
                         $time, act.nx, act.ny, act.nz, act.degen);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (act.nx !== exp.nx)
            begin
                $display("%0t: normal_x expected %0d actual %0d", $time, exp.nx, act.nx);
                errors++;
            end
            if (act.ny !== exp.ny)
            begin
                $display("%0t: normal_y expected %0d actual %0d", $time, exp.ny, act.ny);
                errors++;
            end
            if (act.nz !== exp.nz)
            begin
                $display("%0t: normal_z expected %0d actual %0d", $time, exp.nz, act.nz);
                errors++;
            end
            if (act.degen !== exp.degen)
            begin
                $display("%0t: degenerate expected %0b actual %0b", $time, exp.degen,
                         act.degen);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [COORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic signed [NORM_W-1:0]  normal_x, normal_y, normal_z;
    logic degenerate;

    normal_scoreboard sb;
    bit     calm;
    bit     hold;
    longint cycles;

    triangle_unit_normal_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, always ready when calm, or a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold)
            out_ready <= 1'b0;
        else if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 24);
    end

    // result checking
    always @(posedge clk)
    begin
        normal_t act;
        if (rst_n && out_valid && out_ready)
        begin
            act.nx = normal_x; act.ny = normal_y; act.nz = normal_z;
            act.degen = degenerate;
            sb.check_normal(act);
        end
    end

    // hold the receiver off for a counted stretch
    task automatic hold_receiver();
        hold = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold = 1'b0;
    endtask

    // offer one triangle and wait for it to be taken
    task automatic send_triangle(triangle_t t);
        if (!calm)
        begin
            while ($urandom_range(99) < 24)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        a_x <= t.ax; a_y <= t.ay; a_z <= t.az;
        b_x <= t.bx; b_y <= t.by; b_z <= t.bz;
        c_x <= t.cx; c_y <= t.cy; c_z <= t.cz;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_triangle(t);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return COORD_W'($urandom);
            1: return COORD_W'($signed($urandom_range(64)) - 32);
            default: return COORD_W'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    function automatic triangle_t make_tri(logic signed [COORD_W-1:0] ax, ay, az,
                                           bx, by, bz, cx, cy, cz);
        triangle_t t;
        t.ax = ax; t.ay = ay; t.az = az;
        t.bx = bx; t.by = by; t.bz = bz;
        t.cx = cx; t.cy = cy; t.cz = cz;
        return t;
    endfunction

    function automatic triangle_t random_tri();
        triangle_t t;
        int mode, k;
        mode = $urandom_range(2);
        t = make_tri(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                     rand_coord(mode), rand_coord(mode), rand_coord(mode),
                     rand_coord(mode), rand_coord(mode), rand_coord(mode));
        // collinear or repeated vertices, or a flat z = 0 triangle, now and then
        case ($urandom_range(9))
            0: begin t.cx = t.ax; t.cy = t.ay; t.cz = t.az; end
            1:
            begin
                k = $urandom_range(3);
                t.cx = COORD_W'(t.ax + k * (t.bx - t.ax));
                t.cy = COORD_W'(t.ay + k * (t.by - t.ay));
                t.cz = COORD_W'(t.az + k * (t.bz - t.az));
            end
            2: begin t.az = 0; t.bz = 0; t.cz = 0; end
            default: ;
        endcase
        return t;
    endfunction

    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

    initial
    begin
        triangle_t dir[$];
        sb = new();
        calm = 1'b0;
        hold = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, axis-aligned full scale, extremes
        dir.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5));
        dir.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
        dir.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        dir.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));
        dir.push_back(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
        dir.push_back(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
        dir.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
        dir.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
        dir.push_back(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
        dir.push_back(make_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN));
        dir.push_back(make_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX));
        dir.push_back(make_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX));
        dir.push_back(make_tri(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN));
        dir.push_back(make_tri(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        dir.push_back(make_tri(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        dir.push_back(make_tri(-1, -1, -1, CMAX, 0, 0, 0, CMIN, 0));
        dir.push_back(make_tri(0, 0, 0, 3, 4, 0, -4, 3, 0));
        dir.push_back(make_tri(0, 0, 0, 1, 2, 3, 4, 5, 7));
        dir.push_back(make_tri(CMIN, 0, CMAX, 0, CMAX, CMIN, CMAX, CMIN, 0));
        foreach (dir[i])
            send_triangle(dir[i]);

        // random triangles, with a calm stretch, a hold-off and a drained pause
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300) calm = 1'b1;
            if (n == 600) calm = 1'b0;
            if (n == 800)
                fork
                    hold_receiver();
                join_none
            if (n == 1200)
            begin
                in_valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            send_triangle(random_tri());
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/tun_pkg.sv
rtl/core/triangle_unit_normal_top.sv
rtl/core/tun_checker.sv
test/tb.sv
